FILE: design/t2u_pkg.sv
// Package for the text to UTF-8 transcoder: item structs, encoding codes,
// the internal result-group struct and the UTF-8 encode function.
// No dependencies.
package t2u_pkg;

    // Source encoding codes (value 3 behaves as copy)
    localparam logic [1:0] ENC_LATIN1 = 2'd0;
    localparam logic [1:0] ENC_UTF16  = 2'd1;
    localparam logic [1:0] ENC_COPY   = 2'd2;

    localparam logic [15:0] MARK_NATIVE  = 16'hFEFF;
    localparam logic [15:0] MARK_SWAPPED = 16'hFFFE;
    localparam logic [7:0]  MARK_HI      = 8'hFE;
    localparam logic [7:0]  MARK_LO      = 8'hFF;

    localparam logic [15:0] MAX_ONE_BYTE = 16'h007F;
    localparam logic [15:0] MAX_TWO_BYTE = 16'h07FF;
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    // Up to three UTF-8 bytes of one input item
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            has_data;
        logic            string_end;
    } t2u_grp_t;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
    } t2u_enc_t;

    function automatic t2u_enc_t t2u_encode(input logic [15:0] cp);
        t2u_enc_t r;
        r.bytes = '0;
        if (cp <= MAX_ONE_BYTE) begin
            r.bytes[0] = cp[7:0];
            r.cnt      = 2'd1;
        end else if (cp <= MAX_TWO_BYTE) begin
            r.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            r.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            r.cnt      = 2'd2;
        end else begin
            r.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            r.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            r.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            r.cnt      = 2'd3;
        end
        return r;
    endfunction

endpackage

FILE: design/t2u_decode.sv
// Decode stage: source encoding register, UTF-16 pairing state and the
// per-item encode into a result group. Depends on t2u_pkg.
module t2u_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_data,
    input  logic              accept,
    input  t2u_pkg::in_item_t in_item,
    output logic              grp_need,
    output logic              grp_load,
    output t2u_pkg::t2u_grp_t grp
);
    import t2u_pkg::*;

    logic [1:0] enc_reg;
    logic [7:0] held_reg,   held_next;
    logic       half_reg,   half_next;
    logic       le_reg,     le_next;
    logic       first_reg,  first_next;

    logic       bom_le, bom_be, order_le, drop;
    logic [15:0] unit;
    t2u_enc_t   enc;

    always_comb
    begin
        bom_le   = first_reg && held_reg == MARK_LO && in_item.data_byte == MARK_HI;
        bom_be   = first_reg && held_reg == MARK_HI && in_item.data_byte == MARK_LO;
        order_le = first_reg ? bom_le : le_reg;
        unit     = order_le ? {in_item.data_byte, held_reg} : {held_reg, in_item.data_byte};
        drop     = bom_le || bom_be || unit == MARK_NATIVE || unit == MARK_SWAPPED;

        held_next  = held_reg;
        half_next  = half_reg;
        le_next    = le_reg;
        first_next = first_reg;
        enc        = '0;

        case (enc_reg)
            ENC_LATIN1:
            begin
                enc = t2u_encode({8'h00, in_item.data_byte});
            end
            ENC_UTF16:
            begin
                if (!half_reg)
                begin
                    held_next = in_item.data_byte;
                    half_next = 1'b1;
                end
                else
                begin
                    half_next  = 1'b0;
                    first_next = 1'b0;
                    le_next    = order_le;
                    if (!drop)
                    begin
                        enc = t2u_encode(unit);
                    end
                end
            end
            default:
            begin
                enc.bytes[0] = in_item.data_byte;
                enc.cnt      = 2'd1;
            end
        endcase

        // End of string: restart pairing state
        if (in_item.last_byte)
        begin
            held_next  = '0;
            half_next  = 1'b0;
            le_next    = 1'b0;
            first_next = 1'b1;
        end

        grp.bytes      = enc.bytes;
        grp.has_data   = enc.cnt != 2'd0;
        grp.cnt        = grp.has_data ? enc.cnt : 2'd1;
        grp.string_end = in_item.last_byte;
        // Only items that leave a result group need the result register
        grp_need       = grp.has_data || in_item.last_byte;
        grp_load       = accept && grp_need;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg   <= ENC_LATIN1;
            held_reg  <= '0;
            half_reg  <= 1'b0;
            le_reg    <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            enc_reg   <= cfg_data;
            held_reg  <= '0;
            half_reg  <= 1'b0;
            le_reg    <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            half_reg  <= half_next;
            le_reg    <= le_next;
            first_reg <= first_next;
        end
    end

endmodule

FILE: design/t2u_outbuf.sv
// Result register: holds one result group and hands its bytes out one per
// cycle while out_stall is low. Depends on t2u_pkg.
module t2u_outbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               grp_load,
    input  t2u_pkg::t2u_grp_t  grp,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_stall,
    output t2u_pkg::out_item_t out_item
);
    import t2u_pkg::*;

    logic      valid_reg;
    t2u_grp_t  grp_reg;
    logic [1:0] idx_reg;
    logic      fire, last_slot;

    assign fire      = valid_reg && !out_stall;
    assign last_slot = idx_reg == 2'(grp_reg.cnt - 2'd1);
    assign can_load  = !valid_reg || (fire && last_slot);

    assign out_valid           = valid_reg;
    assign out_item.out_byte   = grp_reg.bytes[idx_reg];
    assign out_item.has_data   = grp_reg.has_data;
    assign out_item.run_last   = last_slot;
    assign out_item.string_end = grp_reg.string_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (grp_load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (fire && last_slot)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            grp_reg <= grp;
        end
    end

endmodule

FILE: design/text_to_utf8_transcoder_core.sv
// Top level of the text to UTF-8 transcoder: decode stage and result register.
// Depends on t2u_pkg, t2u_decode and t2u_outbuf.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall   | in_item  (data_byte, last_byte)
//  out     | output    | out_valid / out_stall | out_item (out_byte, has_data,
//          |           |                       |           run_last, string_end)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (source_encoding)
//
// An item is decoded in the cycle it is accepted; its first result shows
// in the next cycle. The result register sends one byte per cycle while
// out_stall is low. An item gives 0 to 3 result bytes: a Latin-1 byte 1 or
// 2, a UTF-16 pair up to 3. Items with no result (first half of a unit,
// dropped mark) are accepted at once, even while the result register drains,
// unless they end the string. out_stall holds the result register and,
// through it, stalls any input item that has results; reset selects
// Latin-1 with big-endian order and a mark check pending.
module text_to_utf8_transcoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  t2u_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output t2u_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);
    import t2u_pkg::*;

    logic     accept;
    logic     grp_need;
    logic     grp_load;
    logic     can_load;
    t2u_grp_t grp;

    // Config is for the user to write only while idle; the block has no check for it. Take it at once
    assign cfg_ready = 1'b1;

    // Stall only an item that leaves a result group while the result register
    // is still busy; items with no result advance the pairing state at once
    assign in_stall = grp_need && !can_load;
    assign accept   = in_valid && !in_stall;

    t2u_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .accept   (accept),
        .in_item  (in_item),
        .grp_need (grp_need),
        .grp_load (grp_load),
        .grp      (grp)
    );

    t2u_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_load  (grp_load),
        .grp       (grp),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    // A group may overlap a busy result register only as its last byte leaves
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        grp_load && out_valid |-> !out_stall && out_item.run_last)
        else $error("result group loaded over a pending result group");

    // The end-only marker closes a string and its item
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.has_data |-> out_item.run_last && out_item.string_end)
        else $error("end-only marker without run_last and string_end");

    // Bytes of one item follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_item.run_last |=> out_valid)
        else $error("result group ended early");

    // A loaded group always shows on the output next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        grp_load |=> out_valid)
        else $error("loaded result group not presented");
`endif

endmodule

FILE: tb/sv/utf8_stream_checker.sv
`timescale 1ns / 100ps
// Transcoder checker: watches the input, result and register channels and
// predicts the UTF-8 stream. Compares each accepted result with the oldest
// expected one. Depends on t2u_pkg.
module utf8_stream_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  t2u_pkg::in_item_t  in_item,
    input  logic               out_valid,
    input  logic               out_stall,
    input  t2u_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import t2u_pkg::*;

    logic [1:0] enc_mode      = ENC_LATIN1;
    logic [7:0] held_byte     = 8'h00;
    bit         half_pending  = 1'b0;
    bit         little_endian = 1'b0;
    bit         mark_check    = 1'b1;

    out_item_t utf8_expect_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic restart_text();
        held_byte     = 8'h00;
        half_pending  = 1'b0;
        little_endian = 1'b0;
        mark_check    = 1'b1;
    endtask

    // UTF-8 bytes of a 16-bit code point, first byte in the low octet
    function automatic int utf8_seq(input logic [15:0] cp, output logic [23:0] seq);
        seq = '0;
        if (cp[15:7] == 9'd0)
        begin
            seq[7:0] = cp[7:0];
            return 1;
        end
        if (cp[15:11] == 5'd0)
        begin
            seq[15:0] = {2'b10, cp[5:0], 3'b110, cp[10:6]};
            return 2;
        end
        seq = {2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        return 3;
    endfunction

    task automatic transcode_item(input in_item_t it);
        logic [23:0] seq;
        logic [15:0] unit;
        out_item_t   r;
        int          n;
        seq = '0;
        n   = 0;
        case (enc_mode)
            ENC_LATIN1: n = utf8_seq({8'h00, it.data_byte}, seq);
            ENC_UTF16:
            begin
                if (!half_pending)
                begin
                    held_byte    = it.data_byte;
                    half_pending = 1'b1;
                end
                else
                begin
                    half_pending = 1'b0;
                    // only the first unit of a text picks the byte order
                    if (mark_check)
                    begin
                        mark_check    = 1'b0;
                        little_endian = (held_byte == MARK_LO) && (it.data_byte == MARK_HI);
                    end
                    unit = little_endian ? {it.data_byte, held_byte} : {held_byte, it.data_byte};
                    if (unit != MARK_NATIVE && unit != MARK_SWAPPED)
                        n = utf8_seq(unit, seq);
                end
            end
            default:
            begin
                seq[7:0] = it.data_byte;
                n        = 1;
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            r.out_byte   = seq[8*k +: 8];
            r.has_data   = 1'b1;
            r.run_last   = (k == n - 1);
            r.string_end = it.last_byte;
            utf8_expect_q.push_back(r);
        end
        if (it.last_byte)
        begin
            if (n == 0)
            begin
                r.out_byte   = 8'h00;
                r.has_data   = 1'b0;
                r.run_last   = 1'b1;
                r.string_end = 1'b1;
                utf8_expect_q.push_back(r);
            end
            restart_text();
        end
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        string     diff;
        if (utf8_expect_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result byte=%02h has_data=%b run_last=%b end=%b",
                got.out_byte, got.has_data, got.run_last, got.string_end));
            return;
        end
        want = utf8_expect_q.pop_front();
        diff = "";
        if (got.out_byte !== want.out_byte)
            diff = {diff, $sformatf(" out_byte %02h/%02h", got.out_byte, want.out_byte)};
        if (got.has_data !== want.has_data)
            diff = {diff, $sformatf(" has_data %b/%b", got.has_data, want.has_data)};
        if (got.run_last !== want.run_last)
            diff = {diff, $sformatf(" run_last %b/%b", got.run_last, want.run_last)};
        if (got.string_end !== want.string_end)
            diff = {diff, $sformatf(" string_end %b/%b", got.string_end, want.string_end)};
        if (diff != "")
            report_mismatch({"got/expected:", diff});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_mode = ENC_LATIN1;
            restart_text();
            utf8_expect_q.delete();
        end
        else
        begin
            // results leave before this edge's item can produce any
            if (out_valid && !out_stall)
                compare_result(out_item);
            if (cfg_valid && cfg_ready)
            begin
                enc_mode = cfg_data;
                restart_text();
            end
            if (in_valid && !in_stall)
                transcode_item(in_item);
        end
        pending = utf8_expect_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the transcoder testbench: clock, reset, stimulus and verdict.
// Depends on t2u_pkg, text_to_utf8_transcoder_core and utf8_stream_checker.
module testbench;
    import t2u_pkg::*;

    // code 3 has no name in the package; the block treats it as a copy
    localparam logic [1:0] ENC_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_data;

    int fail_count;
    int pending;

    int         items_sent  = 0;
    int         burst_left  = 0;
    bit         pressure_req = 1'b0;
    logic [7:0] text_q[$];

    text_to_utf8_transcoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    utf8_stream_checker stream_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hard stop, well beyond what the slowest legal run needs.
    initial
    begin
        #2_000_000;
        $display("** text_to_utf8_transcoder_core: FAILED **");
        $finish;
    end

    // Receiver stall pattern: segments of random length, each with its own
    // stall density, from never to nearly always. The first segment after
    // pressure_req rises holds the result channel for a long stretch while
    // the sender keeps offering, so the block fills up and stalls its input.
    initial
    begin : out_stall_gen
        int  span;
        int  pct;
        bit  pressure_done;
        out_stall     = 1'b0;
        pressure_done = 1'b0;
        forever
        begin
            if (pressure_req && !pressure_done)
            begin
                pressure_done = 1'b1;
                span          = 80;
                pct           = 100;
            end
            else
            begin
                span = $urandom_range(5, 40);
                case ($urandom_range(0, 4))
                    0, 1:    pct = 0;
                    2:       pct = 25;
                    3:       pct = 60;
                    default: pct = 90;
                endcase
            end
            repeat (span)
            begin
                @(negedge clk);
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // Offer one item and hold it until accepted. Entered and left at a
    // falling edge. Between bursts, drop valid for a random gap; a zero gap
    // keeps valid high into the next burst.
    task automatic send_item(input logic [7:0] data, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_item  <= '{data_byte: data, last_byte: last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    // Send the queued bytes as one text, last flag on the final byte.
    task automatic flush_text();
        for (int k = 0; k < text_q.size(); k++)
            send_item(text_q[k], k == text_q.size() - 1);
        text_q.delete();
    endtask

    // Write the encoding register once the block has drained. Items that give
    // no result may still be in flight, so keep waiting past that point.
    task automatic write_encoding(input logic [1:0] code);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_data  <= code;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random UTF-16 unit, biased toward each output length, surrogates,
    // marks and the boundaries between lengths.
    function automatic logic [15:0] pick_unit();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom_range(16'h0000, 16'h007F));
            3, 4:    return 16'($urandom_range(16'h0080, 16'h07FF));
            5, 6:    return 16'($urandom_range(16'h0800, 16'hFFFF));
            7:       return 16'($urandom_range(16'hD800, 16'hDFFF));
            8:       return $urandom_range(0, 1) ? MARK_NATIVE : MARK_SWAPPED;
            default:
                case ($urandom_range(0, 5))
                    0:       return 16'h0000;
                    1:       return 16'h007F;
                    2:       return 16'h0080;
                    3:       return 16'h07FF;
                    4:       return 16'h0800;
                    default: return 16'hFFFF;
                endcase
        endcase
    endfunction

    // One UTF-16 text: mostly well formed with an optional leading mark,
    // sometimes with a stray trailing byte, sometimes plain noise.
    task automatic send_utf16_text();
        int          order;
        logic [15:0] unit;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 7))
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            order = $urandom_range(0, 2);
            if (order == 1)
            begin
                text_q.push_back(MARK_LO);
                text_q.push_back(MARK_HI);
            end
            else if (order == 2)
            begin
                text_q.push_back(MARK_HI);
                text_q.push_back(MARK_LO);
            end
            repeat ($urandom_range(1, 6))
            begin
                unit = pick_unit();
                if (order == 1)
                begin
                    text_q.push_back(unit[7:0]);
                    text_q.push_back(unit[15:8]);
                end
                else
                begin
                    text_q.push_back(unit[15:8]);
                    text_q.push_back(unit[7:0]);
                end
            end
            if ($urandom_range(0, 5) == 0)
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        flush_text();
    endtask

    // Select an encoding and send random texts until about budget items went.
    task automatic run_phase(input logic [1:0] code, input int budget);
        int stop_at;
        write_encoding(code);
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if (code == ENC_UTF16)
                send_utf16_text();
            else
            begin
                repeat ($urandom_range(1, 10))
                    text_q.push_back(8'($urandom_range(0, 255)));
                flush_text();
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = ENC_LATIN1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Latin-1 out of reset: both ends of the one-byte and two-byte ranges
        text_q = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        flush_text();

        write_encoding(ENC_UTF16);
        // little-endian mark, 'A', back-to-back later marks, a surrogate,
        // then a stray final byte that leaves only the end marker
        text_q = '{8'hFF, 8'hFE, 8'h41, 8'h00, 8'hFE, 8'hFF, 8'hFF, 8'hFE,
                   8'h00, 8'hD8, 8'h12};
        flush_text();
        // big-endian mark, then the top unit
        text_q = '{8'hFE, 8'hFF, 8'hFF, 8'hFF};
        flush_text();
        // no mark: last two-byte and first three-byte units
        text_q = '{8'h07, 8'hFF, 8'h08, 8'h00};
        flush_text();
        // a text that is only a mark ends with nothing to say
        text_q = '{8'hFE, 8'hFF};
        flush_text();

        // Random part; hold the result channel early in the first long phase
        pressure_req = 1'b1;
        run_phase(ENC_UTF16, 120);
        run_phase(ENC_LATIN1, 50);
        run_phase(ENC_COPY, 40);
        run_phase(ENC_UTF16, 70);
        run_phase(ENC_UNUSED, 25);
        run_phase(ENC_LATIN1, 25);
        run_phase(ENC_UTF16, 20);

        // Drain, then wait on for any stray result to show
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("** text_to_utf8_transcoder_core: PASSED **");
        else
            $display("** text_to_utf8_transcoder_core: FAILED **");
        $finish;
    end

endmodule

FILE: text_to_utf8_transcoder_core.f
design/t2u_pkg.sv
design/t2u_decode.sv
design/t2u_outbuf.sv
design/text_to_utf8_transcoder_core.sv
tb/sv/utf8_stream_checker.sv
tb/sv/testbench.sv
